[hdl/chs_pkg.sv]
// chs_pkg: shared types and codes for the chained hash set.
// Used by chs_front, chs_queue, chs_back and chained_hash_set; no dependencies.
`default_nettype none

package chs_pkg;

	localparam int unsigned KEY_W = 31;

	// request kind codes on the port
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;

	// response status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_DONE   = 2'd0;
	localparam status_t ST_ABSENT = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_SEARCH
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} back_state_t;

endpackage

`default_nettype wire

[hdl/chained_hash_set.sv]
// chained_hash_set: top level of the hash set with bounded bucket chains.
// Depends on chs_pkg, chs_front, chs_queue and chs_back.
//
// A set of 31-bit keys (duplicates allowed) held in BUCKETS buckets of SLOTS
// entries; a key lives in bucket key mod BUCKETS. Each request transfer carries
// a kind (0 insert, 1 delete every copy, 2 or 3 search) and a key; each one
// yields exactly one response transfer with status 0 (done / found),
// 1 (key not present) or 2 (insert rejected, bucket full). Requests are
// answered in order. The front end decodes the kind and reduces the key to a
// bucket index in two register stages (a reciprocal multiply, then a
// multiply-back with a single correction), and hands the request to a
// two-entry queue. The back end works one request at a time: it reads the
// bucket row when it takes a request from the queue, then compares all slots
// and writes the row back as it registers the response; this step waits
// while an earlier response is still held and rsp_ready is low. The response
// sits in an output register, so the next request is read while a response
// waits. After reset the back end runs a clearing pass over the slot valid
// marks, one bucket per cycle through every bucket; req_ready stays low until
// it ends.
`default_nettype none

module chained_hash_set #(
	parameter int unsigned BUCKETS = 8,
	parameter int unsigned SLOTS   = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire logic [1:0]                kind,
	input  wire logic [chs_pkg::KEY_W-1:0] key,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output logic [1:0]                     status
);

	// bucket index width, one bit minimum for a single bucket
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic           clearing;
	logic           push, full, pop, nonempty;
	chs_pkg::item_t push_item, head_item;
	logic [BW-1:0]  push_bucket, head_bucket;

	// front end: decode and bucket reduction
	chs_front #(
		.BUCKETS (BUCKETS),
		.BW      (BW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.enable      (!clearing),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.kind        (kind),
		.key         (key),
		.push        (push),
		.push_item   (push_item),
		.push_bucket (push_bucket),
		.full        (full)
	);

	// decoupling queue
	chs_queue #(
		.BW (BW)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_item   (push_item),
		.push_bucket (push_bucket),
		.full        (full),
		.pop         (pop),
		.nonempty    (nonempty),
		.head_item   (head_item),
		.head_bucket (head_bucket)
	);

	// back end: bucket read, compare, write back, respond
	chs_back #(
		.BUCKETS (BUCKETS),
		.SLOTS   (SLOTS),
		.BW      (BW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (nonempty),
		.q_item    (head_item),
		.q_bucket  (head_bucket),
		.pop       (pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status)
	);

endmodule

`default_nettype wire

[hdl/chs_front.sv]
// chs_front: request intake, kind decode and bucket index (key mod BUCKETS).
// Depends on chs_pkg. Two register stages; feeds chs_queue.
`default_nettype none

module chs_front #(
	parameter int unsigned BUCKETS = 8,
	parameter int unsigned BW      = 3
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      enable,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire logic [1:0]                kind,
	input  wire logic [chs_pkg::KEY_W-1:0] key,
	output logic                           push,
	output chs_pkg::item_t                 push_item,
	output logic [BW-1:0]                  push_bucket,
	input  wire logic                      full
);

	localparam int unsigned KW = chs_pkg::KEY_W;
	localparam int unsigned RW = BW + 1;
	// floor(2^31 / BUCKETS): quotient estimate is low by at most one
	localparam logic [32:0] ONE31 = 33'd1 << 31;
	localparam logic [31:0] RECIP = 32'(ONE31 / BUCKETS);

	logic           v1_q, v2_q;
	logic           adv1, adv2, acc;
	chs_pkg::item_t item_s1, item_s2;
	chs_pkg::op_t   op_dec;
	logic [KW-1:0]  quo_s2;
	logic [63:0]    recip_prod;
	logic [41:0]    back_prod;
	logic [KW-1:0]  diff;
	logic [RW-1:0]  rem;

	assign adv2      = v2_q && !full;
	assign adv1      = v1_q && (!v2_q || adv2);
	assign req_ready = enable && (!v1_q || adv1);
	assign acc       = req_valid && req_ready;

	always_comb begin
		unique case (kind)
			chs_pkg::KIND_INSERT: op_dec = chs_pkg::OP_INSERT;
			chs_pkg::KIND_DELETE: op_dec = chs_pkg::OP_DELETE;
			default:              op_dec = chs_pkg::OP_SEARCH;
		endcase
	end

	assign recip_prod = 64'(item_s1.key) * 64'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			v1_q <= acc || (v1_q && !adv1);
			v2_q <= adv1 || (v2_q && !adv2);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.op  <= op_dec;
			item_s1.key <= key;
		end
		if (adv1) begin
			item_s2 <= item_s1;
			quo_s2  <= recip_prod[2*KW-1:KW];
		end
	end

	// remainder below 2*BUCKETS, one correction step
	assign back_prod = 42'(quo_s2) * 42'(BUCKETS);
	assign diff      = item_s2.key - back_prod[KW-1:0];
	assign rem       = diff[RW-1:0];

	always_comb begin
		if (rem >= RW'(BUCKETS))
			push_bucket = BW'(rem - RW'(BUCKETS));
		else
			push_bucket = BW'(rem);
	end

	assign push      = adv2;
	assign push_item = item_s2;

endmodule

`default_nettype wire

[hdl/chs_queue.sv]
// chs_queue: two-entry FIFO between front and back ends.
// Depends on chs_pkg for the item type.
`default_nettype none

module chs_queue #(
	parameter int unsigned BW = 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire chs_pkg::item_t push_item,
	input  wire logic [BW-1:0]  push_bucket,
	output logic                full,
	input  wire logic           pop,
	output logic                nonempty,
	output chs_pkg::item_t      head_item,
	output logic [BW-1:0]       head_bucket
);

	localparam int unsigned DEPTH = 2;

	chs_pkg::item_t item_q   [DEPTH];
	logic [BW-1:0]  bucket_q [DEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign full        = (cnt_q == 2'(DEPTH));
	assign nonempty    = (cnt_q != 2'd0);
	assign head_item   = item_q[rp_q];
	assign head_bucket = bucket_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wp_q]   <= push_item;
			bucket_q[wp_q] <= push_bucket;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

[hdl/chs_back.sv]
// chs_back: bucket memories, reset clearing pass, and the read/compare/write-back
// sequencer with response register. Depends on chs_pkg.
`default_nettype none

module chs_back #(
	parameter int unsigned BUCKETS = 8,
	parameter int unsigned SLOTS   = 4,
	parameter int unsigned BW      = 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire chs_pkg::item_t q_item,
	input  wire logic [BW-1:0]  q_bucket,
	output logic                pop,
	output logic                clearing,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output logic [1:0]          status
);

	localparam int unsigned KW = chs_pkg::KEY_W;

	logic [SLOTS*KW-1:0] key_mem   [BUCKETS];
	logic [SLOTS-1:0]    valid_mem [BUCKETS];

	chs_pkg::back_state_t state_q, state_d;
	logic [BW-1:0]        clr_cnt_q;
	logic                 clr_last;

	chs_pkg::op_t        op_q;
	logic [KW-1:0]       key_q;
	logic [BW-1:0]       bkt_q;
	logic [SLOTS*KW-1:0] krow_q;
	logic [SLOTS-1:0]    vrow_q;

	logic [SLOTS-1:0]    match, free, first_free;
	logic [SLOTS*KW-1:0] krow_new;
	logic [SLOTS-1:0]    vrow_new;
	logic                fire, vwr_en, kwr_en;
	logic [BW-1:0]       wr_addr;
	logic [SLOTS-1:0]    vwr_data;
	chs_pkg::status_t    status_new;
	logic                rsp_valid_q;
	chs_pkg::status_t    status_q;

	assign clr_last = (clr_cnt_q == BW'(BUCKETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= chs_pkg::S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == chs_pkg::S_CLEAR)
				clr_cnt_q <= clr_cnt_q + BW'(1);
		end
	end

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			match[s] = vrow_q[s] && (krow_q[s*KW +: KW] == key_q);
			free[s]  = !vrow_q[s];
		end
		first_free = free & (~free + SLOTS'(1));
		for (int s = 0; s < SLOTS; s++)
			krow_new[s*KW +: KW] = first_free[s] ? key_q : krow_q[s*KW +: KW];

		unique case (op_q)
			chs_pkg::OP_INSERT: begin
				vrow_new   = vrow_q | first_free;
				status_new = (|free) ? chs_pkg::ST_DONE : chs_pkg::ST_FULL;
			end
			chs_pkg::OP_DELETE: begin
				vrow_new   = vrow_q & ~match;
				status_new = (|match) ? chs_pkg::ST_DONE : chs_pkg::ST_ABSENT;
			end
			default: begin
				vrow_new   = vrow_q;
				status_new = (|match) ? chs_pkg::ST_DONE : chs_pkg::ST_ABSENT;
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		fire     = 1'b0;
		vwr_en   = 1'b0;
		kwr_en   = 1'b0;
		wr_addr  = bkt_q;
		vwr_data = vrow_new;
		unique case (state_q)
			chs_pkg::S_CLEAR: begin
				vwr_en   = 1'b1;
				wr_addr  = clr_cnt_q;
				vwr_data = '0;
				if (clr_last)
					state_d = chs_pkg::S_IDLE;
			end
			chs_pkg::S_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = chs_pkg::S_EXEC;
				end
			end
			chs_pkg::S_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					fire    = 1'b1;
					vwr_en  = 1'b1;
					kwr_en  = (op_q == chs_pkg::OP_INSERT) && (|free);
					state_d = chs_pkg::S_IDLE;
				end
			end
			default: state_d = chs_pkg::S_CLEAR;
		endcase
	end

	// memories: one row per bucket, read data registered
	always_ff @(posedge clk) begin
		if (pop) begin
			krow_q <= key_mem[q_bucket];
			vrow_q <= valid_mem[q_bucket];
			op_q   <= q_item.op;
			key_q  <= q_item.key;
			bkt_q  <= q_bucket;
		end
		if (vwr_en)
			valid_mem[wr_addr] <= vwr_data;
		if (kwr_en)
			key_mem[wr_addr] <= krow_new;
		if (fire)
			status_q <= status_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (fire)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign clearing  = (state_q == chs_pkg::S_CLEAR);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status != chs_pkg::ST_UNUSED))
		else $error("reserved status code on response");

	a_insert_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_q == chs_pkg::OP_INSERT && status_new == chs_pkg::ST_DONE)
		|-> ($countones(vrow_new) == $countones(vrow_q) + 1))
		else $error("insert did not claim exactly one slot");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chs_pkg::S_CLEAR && state_d == chs_pkg::S_IDLE) |-> clr_last)
		else $error("clearing pass ended early");

	a_delete_no_match_left: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_q == chs_pkg::OP_DELETE) |-> ((vrow_new & match) == '0))
		else $error("delete left a matching slot valid");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// testbench: self-checking regression for chained_hash_set (8 buckets x 4 slots).
// Depends on chs_pkg and the chained_hash_set RTL; keeps its own copy of the bucket
// contents to predict the status of every request.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned KW          = chs_pkg::KEY_W;
	localparam int unsigned BUCKETS     = 8;
	localparam int unsigned SLOTS       = 4;
	localparam int unsigned ENTRIES     = BUCKETS * SLOTS;
	localparam int unsigned RANDOM_OPS  = 700;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned POOL_SIZE   = 16;

	// kinds 2 and 3 both decode as a lookup
	localparam logic [1:0] KIND_SEARCH     = 2'd2;
	localparam logic [1:0] KIND_SEARCH_ALT = 2'd3;
	localparam logic [KW-1:0] KEY_MAX      = {KW{1'b1}};

	typedef struct packed {
		logic [1:0]    kind;
		logic [KW-1:0] key;
	} request_t;

	// DUT connections; every input starts at a known value
	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	logic [1:0]    kind      = chs_pkg::KIND_INSERT;
	logic [KW-1:0] key       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	logic [1:0]    status;

	// shadow copy of the bucket memories
	logic [KW-1:0] shadow_key  [ENTRIES];
	bit            shadow_used [ENTRIES];

	request_t           req_backlog[$];   // requests not yet offered
	chs_pkg::status_t   status_due[$];    // predicted status, oldest first
	int unsigned mismatches  = 0;
	int unsigned rsp_count   = 0;
	int unsigned cycle_count = 0;

	// handshake flags captured at the rising edge, consumed at the falling edge
	bit req_taken = 1'b0;
	bit rsp_taken = 1'b0;

	// sender / receiver pacing
	int unsigned send_gap = 0, send_phase = 0;
	bit          send_calm = 1'b0;
	int unsigned recv_gap = 0, recv_phase = 0;
	bit          recv_calm = 1'b0;
	int unsigned hold_left = 0, holds_used = 0, hold_at = 60;

	chained_hash_set #(
		.BUCKETS(BUCKETS),
		.SLOTS  (SLOTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind     (kind),
		.key      (key),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status   (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow buckets and return the status it must produce.
	// Only slots with their valid mark set are ever compared.
	function automatic chs_pkg::status_t hash_set_update(logic [1:0] op, logic [KW-1:0] k);
		int unsigned      base;
		chs_pkg::status_t st;
		bit               placed;
		base   = (k % BUCKETS) * SLOTS;
		placed = 1'b0;
		case (op)
			chs_pkg::KIND_INSERT: begin
				st = chs_pkg::ST_FULL;
				// lowest free slot takes the key; duplicates are fine
				for (int s = 0; s < SLOTS; s++) begin
					if (!placed && !shadow_used[base + s]) begin
						shadow_key[base + s]  = k;
						shadow_used[base + s] = 1'b1;
						placed = 1'b1;
						st     = chs_pkg::ST_DONE;
					end
				end
			end
			chs_pkg::KIND_DELETE: begin
				st = chs_pkg::ST_ABSENT;
				// every copy goes
				for (int s = 0; s < SLOTS; s++) begin
					if (shadow_used[base + s] && shadow_key[base + s] == k) begin
						shadow_used[base + s] = 1'b0;
						st = chs_pkg::ST_DONE;
					end
				end
			end
			default: begin
				st = chs_pkg::ST_ABSENT;
				for (int s = 0; s < SLOTS; s++) begin
					if (shadow_used[base + s] && shadow_key[base + s] == k)
						st = chs_pkg::ST_DONE;
				end
			end
		endcase
		return st;
	endfunction

	// Idle length after a transfer: mostly none or short, now and then long.
	// A calm stretch has no idling at all.
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 96)
			return $urandom_range(3, 8);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic queue_op(logic [1:0] op, logic [KW-1:0] k);
		request_t r;
		r.kind = op;
		r.key  = k;
		req_backlog.insert(req_backlog.size(), r);
	endtask

	// Monitor: both handshakes sampled at the rising edge.
	// Response is checked before the new request's prediction is queued,
	// so a same-edge pair still lines up with the oldest expectation.
	always @(posedge clk) begin
		chs_pkg::status_t want;
		req_taken = arst_n && req_valid && req_ready;
		rsp_taken = arst_n && rsp_valid && rsp_ready;
		if (rsp_taken) begin
			rsp_count++;
			if (status_due.size() == 0) begin
				if (mismatches < 10)
					$display("response %0d: status %0d with no request outstanding",
						rsp_count, status);
				mismatches++;
			end else begin
				want = status_due.pop_front();
				if (status !== want) begin
					if (mismatches < 10)
						$display("response %0d: status expected %0d, got %0d",
							rsp_count, want, status);
					mismatches++;
				end
			end
		end
		if (req_taken)
			status_due.insert(status_due.size(), hash_set_update(kind, key));
	end

	// Driver: changes the request at the falling edge. Valid and payload hold
	// until the transfer; a back-to-back item keeps valid high without a dip.
	always @(negedge clk) begin
		logic          nxt_valid;
		logic [1:0]    nxt_kind;
		logic [KW-1:0] nxt_key;
		request_t      r;
		nxt_valid = req_valid;
		nxt_kind  = kind;
		nxt_key   = key;
		if (req_valid && req_taken)
			nxt_valid = 1'b0;
		if (arst_n && !nxt_valid) begin
			if (send_gap != 0) begin
				send_gap--;
			end else if (req_backlog.size() != 0) begin
				r         = req_backlog.pop_front();
				nxt_valid = 1'b1;
				nxt_kind  = r.kind;
				nxt_key   = r.key;
				if (send_phase == 0) begin
					send_phase = $urandom_range(10, 60);
					send_calm  = ($urandom_range(0, 3) == 0);
				end
				send_phase--;
				send_gap = pick_gap(send_calm);
			end
		end
		req_valid <= nxt_valid;
		kind      <= nxt_kind;
		key       <= nxt_key;
	end

	// Long hold-off on the response side, counted in its own process. The
	// sender keeps going, so the queue and pipeline fill and req_ready drops.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_used < 2 && rsp_count >= hold_at) begin
			hold_left  <= HOLD_CYCLES;
			holds_used <= holds_used + 1;
			hold_at    <= hold_at + 300;
		end
	end

	// Receiver: random ready, low throughout a hold-off.
	always @(negedge clk) begin
		logic rdy;
		if (rsp_taken) begin
			if (recv_phase == 0) begin
				recv_phase = $urandom_range(10, 60);
				recv_calm  = ($urandom_range(0, 3) == 0);
			end
			recv_phase--;
			recv_gap = pick_gap(recv_calm);
		end
		if (hold_left != 0) begin
			rdy = 1'b0;
		end else if (recv_gap != 0) begin
			rdy = 1'b0;
			recv_gap--;
		end else begin
			rdy = 1'b1;
		end
		rsp_ready <= rdy;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("chained_hash_set regression: fail");
			$finish;
		end
	end

	initial begin
		logic [KW-1:0] pool [POOL_SIZE];
		logic [KW-1:0] k;
		logic [1:0]    op;
		int unsigned   r;

		// Directed: empty-set misses, fill bucket 0 past capacity with a
		// duplicate, delete all copies, both lookup kinds, key extremes.
		queue_op(KIND_SEARCH, '0);                                  // miss on empty set
		queue_op(chs_pkg::KIND_DELETE, '0);                         // delete of absent key
		queue_op(chs_pkg::KIND_INSERT, '0);
		queue_op(chs_pkg::KIND_INSERT, '0);                         // duplicate
		queue_op(chs_pkg::KIND_INSERT, KW'(BUCKETS));
		queue_op(chs_pkg::KIND_INSERT, KW'(KEY_MAX - (KEY_MAX % BUCKETS))); // bucket 0 full
		queue_op(chs_pkg::KIND_INSERT, KW'(2 * BUCKETS));           // rejected
		queue_op(KIND_SEARCH, '0);
		queue_op(KIND_SEARCH_ALT, KW'(BUCKETS));                    // kind 3 looks up
		queue_op(chs_pkg::KIND_DELETE, '0);                         // both copies go
		queue_op(KIND_SEARCH, '0);
		queue_op(chs_pkg::KIND_INSERT, KW'(2 * BUCKETS));           // freed slot reused
		queue_op(chs_pkg::KIND_INSERT, KEY_MAX);
		queue_op(KIND_SEARCH_ALT, KEY_MAX);
		queue_op(KIND_SEARCH, KW'(KEY_MAX - BUCKETS));              // same bucket, other key
		queue_op(chs_pkg::KIND_DELETE, KEY_MAX);
		queue_op(KIND_SEARCH, KEY_MAX);
		queue_op(chs_pkg::KIND_INSERT, 31'h5555_5555);
		queue_op(chs_pkg::KIND_INSERT, 31'h2AAA_AAAA);
		queue_op(KIND_SEARCH, 31'h5555_5555);
		queue_op(KIND_SEARCH_ALT, 31'h2AAA_AAAA);
		queue_op(chs_pkg::KIND_DELETE, 31'h2AAA_AAAA);

		// Random: mostly a small key pool so buckets fill, hit and drain;
		// the rest are arbitrary keys that mostly miss.
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = KW'($urandom());
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if ($urandom_range(0, 19) == 0)
				pool[$urandom_range(0, POOL_SIZE - 1)] = KW'($urandom());
			if ($urandom_range(0, 9) < 7)
				k = pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = KW'($urandom());
			r = $urandom_range(0, 99);
			if (r < 40)
				op = chs_pkg::KIND_INSERT;
			else if (r < 60)
				op = chs_pkg::KIND_DELETE;
			else if (r < 90)
				op = KIND_SEARCH;
			else
				op = KIND_SEARCH_ALT;
			queue_op(op, k);
		end

		// hold reset, then release it at a falling edge, away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// everything offered and taken, then every response back
		while (req_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		// catch any stray response
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("chained_hash_set regression: pass");
		else
			$display("chained_hash_set regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
